// ----- rtl/core/mbd_pkg.sv -----
// Shared types and constants for the RGBA mipmap box downsampler.
package mbd_pkg;

    // Channel and sum widths
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 7;
    localparam int LANE_N   = 4;
    localparam int DIM_W    = 12;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // Filter mode of the current level
    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_PAIR = 2'd1,
        MODE_BOX  = 2'd2
    } mode_t;

endpackage

// ----- rtl/core/mbd_lane.sv -----
// One channel lane: pair sum for the line store and the filtered channel value.
module mbd_lane (
    input  mbd_pkg::mode_t                mode,
    input  logic [mbd_pkg::PIX_W-1:0]     hold,
    input  logic [mbd_pkg::PIX_W-1:0]     pix,
    input  logic [mbd_pkg::SUM_W-1:0]     row_sum,
    output logic [mbd_pkg::SUM_W-1:0]     pair_sum,
    output logic [mbd_pkg::PIX_W-1:0]     result
);

    logic [mbd_pkg::PIX_W-1:0] box_val;
    logic [mbd_pkg::PIX_W-1:0] pair_val;

    // Quarter-weight horizontal pair, at most 126
    assign pair_sum = mbd_pkg::SUM_W'(hold >> 2) + mbd_pkg::SUM_W'(pix >> 2);

    // Add the stored pair of the row above
    assign box_val  = mbd_pkg::PIX_W'(pair_sum) + mbd_pkg::PIX_W'(row_sum);

    // Half-weight pair along the single long dimension
    assign pair_val = mbd_pkg::PIX_W'(hold >> 1) + mbd_pkg::PIX_W'(pix >> 1);

    // Select by level mode
    always_comb begin
        case (mode)
            mbd_pkg::MODE_BOX:  result = box_val;
            mbd_pkg::MODE_PAIR: result = pair_val;
            mbd_pkg::MODE_PASS: result = pix;
            default:            result = pix;
        endcase
    end

endmodule

// ----- rtl/core/mbd_line_store.sv -----
// Line store holding the packed pair sums of the last even row.
module mbd_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [AW-1:0]                            wr_addr,
    input  logic [mbd_pkg::LANE_N*mbd_pkg::SUM_W-1:0] wr_data,
    input  logic                                     rd_en,
    input  logic [AW-1:0]                            rd_addr,
    output logic [mbd_pkg::LANE_N*mbd_pkg::SUM_W-1:0] rd_data
);

    logic [mbd_pkg::LANE_N*mbd_pkg::SUM_W-1:0] mem [DEPTH];
    logic [mbd_pkg::LANE_N*mbd_pkg::SUM_W-1:0] rd_data_reg;

    // Write one slot per pair
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/mipmap_box_downsample_rgba.sv -----
// Top level of the RGBA8 box-filter mipmap downsampler.
// A result is on m_* in the cycle after the item that completes its pair is accepted.
// Throughput: one pixel per cycle while s_ready is high; four channel lanes work in parallel on each item.
// The line store is read one item ahead (first pixel of an odd-row pair), so its
// registered read is ready for the second pixel. Output register frees s_ready while m_ready is high.
// Reset (aresetn low, synchronous): dimensions 1x1, position counters zero, no result held.
module mipmap_box_downsample_rgba #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mbd_pkg::DIM_W-1:0]         cfg_data,
    // pixel input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mbd_pkg::PIX_W-1:0]         s_red_in,
    input  logic [mbd_pkg::PIX_W-1:0]         s_green_in,
    input  logic [mbd_pkg::PIX_W-1:0]         s_blue_in,
    input  logic [mbd_pkg::PIX_W-1:0]         s_alpha_in,
    // pixel result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mbd_pkg::PIX_W-1:0]         m_red_out,
    output logic [mbd_pkg::PIX_W-1:0]         m_green_out,
    output logic [mbd_pkg::PIX_W-1:0]         m_blue_out,
    output logic [mbd_pkg::PIX_W-1:0]         m_alpha_out,
    output logic                              m_frame_end
);

    localparam int WDW       = $clog2(MAX_WIDTH + 1);
    localparam int HDW       = $clog2(MAX_HEIGHT + 1);
    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int SUM_DEPTH = MAX_WIDTH / 2;
    localparam int AW        = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
    localparam int PW        = mbd_pkg::PIX_W;
    localparam int SW        = mbd_pkg::SUM_W;
    localparam int LN        = mbd_pkg::LANE_N;

    // Zero reads as one, oversize saturates at the maximum
    function automatic int unsigned clamp_dim(input logic [mbd_pkg::DIM_W-1:0] v,
                                              input int unsigned max_dim);
        int unsigned r;
        if (v == '0) begin
            r = 1;
        end else if (32'(v) > max_dim) begin
            r = max_dim;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    logic [WDW-1:0] width_reg;
    logic [HDW-1:0] height_reg;
    logic [XW-1:0]  col_reg;
    logic [XW-1:0]  col_next;
    logic [YW-1:0]  row_reg;
    logic [YW-1:0]  row_next;
    logic [PW-1:0]  hold_reg [LN];
    logic [PW-1:0]  res_reg  [LN];
    logic           m_valid_reg;
    logic           frame_end_reg;

    logic           cfg_write;
    logic           accept;
    logic [PW-1:0]  pix [LN];
    logic [WDW-1:0] even_w;
    logic [HDW-1:0] even_h;
    logic [WDW-1:0] col_ext;
    logic [HDW-1:0] row_ext;
    logic           col_in;
    logic           row_in;
    logic           col_last;
    logic           row_last;
    logic           col_wrap;
    logic           row_wrap;
    logic           wide;
    logic           tall;
    mbd_pkg::mode_t mode;
    logic           hold_en;
    logic           rd_en;
    logic           wr_en;
    logic           produce;
    logic           last;
    logic [AW-1:0]  slot;
    logic [LN*SW-1:0] wr_data;
    logic [LN*SW-1:0] rd_data;
    logic [SW-1:0]  pair_sum [LN];
    logic [PW-1:0]  result   [LN];

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index == mbd_pkg::CFG_IMAGE_WIDTH ||
                        cfg_index == mbd_pkg::CFG_IMAGE_HEIGHT);
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    assign pix[0] = s_red_in;
    assign pix[1] = s_green_in;
    assign pix[2] = s_blue_in;
    assign pix[3] = s_alpha_in;

    // Position decode against the even-rounded dimensions
    assign even_w   = {width_reg[WDW-1:1], 1'b0};
    assign even_h   = {height_reg[HDW-1:1], 1'b0};
    assign col_ext  = WDW'(col_reg);
    assign row_ext  = HDW'(row_reg);
    assign col_in   = col_ext < even_w;
    assign row_in   = row_ext < even_h;
    assign col_last = col_ext == WDW'(even_w - 1'b1);
    assign row_last = row_ext == HDW'(even_h - 1'b1);
    assign col_wrap = WDW'(col_ext + 1'b1) >= width_reg;
    assign row_wrap = HDW'(row_ext + 1'b1) >= height_reg;
    assign wide     = width_reg != WDW'(1);
    assign tall     = height_reg != HDW'(1);

    always_comb begin
        if (wide && tall) begin
            mode = mbd_pkg::MODE_BOX;
        end else if (wide || tall) begin
            mode = mbd_pkg::MODE_PAIR;
        end else begin
            mode = mbd_pkg::MODE_PASS;
        end
    end

    // Per-item control: capture first of pair, line store access, result
    always_comb begin
        hold_en = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        produce = 1'b0;
        last    = 1'b0;
        case (mode)
            mbd_pkg::MODE_BOX: begin
                hold_en = col_in && row_in && !col_reg[0];
                rd_en   = col_in && row_in && !col_reg[0] && row_reg[0];
                wr_en   = col_in && row_in && col_reg[0] && !row_reg[0];
                produce = col_in && row_in && col_reg[0] && row_reg[0];
                last    = col_last && row_last;
            end
            mbd_pkg::MODE_PAIR: begin
                if (wide) begin
                    hold_en = col_in && !col_reg[0];
                    produce = col_in && col_reg[0];
                    last    = col_last;
                end else begin
                    hold_en = row_in && !row_reg[0];
                    produce = row_in && row_reg[0];
                    last    = row_last;
                end
            end
            mbd_pkg::MODE_PASS: begin
                produce = 1'b1;
                last    = 1'b1;
            end
            default: begin
                produce = 1'b0;
            end
        endcase
    end

    assign slot = AW'(col_reg >> 1);

    // Advance raster position, wrap at end of row and level
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap) begin
            col_next = '0;
            row_next = row_wrap ? '0 : YW'(row_ext + 1'b1);
        end else begin
            col_next = XW'(col_ext + 1'b1);
        end
    end

    // Channel lanes
    for (genvar l = 0; l < LN; l++) begin : g_lane
        mbd_lane u_lane (
            .mode     (mode),
            .hold     (hold_reg[l]),
            .pix      (pix[l]),
            .row_sum  (rd_data[l*SW +: SW]),
            .pair_sum (pair_sum[l]),
            .result   (result[l])
        );
        assign wr_data[l*SW +: SW] = pair_sum[l];
    end

    mbd_line_store #(
        .DEPTH (SUM_DEPTH),
        .AW    (AW)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (accept && wr_en),
        .wr_addr (slot),
        .wr_data (wr_data),
        .rd_en   (accept && rd_en),
        .rd_addr (slot),
        .rd_data (rd_data)
    );

    // Configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WDW'(1);
            height_reg <= HDW'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_write) begin
            if (cfg_index == mbd_pkg::CFG_IMAGE_WIDTH) begin
                width_reg <= WDW'(clamp_dim(cfg_data, MAX_WIDTH));
            end else begin
                height_reg <= HDW'(clamp_dim(cfg_data, MAX_HEIGHT));
            end
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Hold the first pixel of a pair
    always_ff @(posedge aclk) begin
        if (accept && hold_en) begin
            for (int l = 0; l < LN; l++) begin
                hold_reg[l] <= pix[l];
            end
        end
    end

    // Output register: load on a result, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && produce) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && produce) begin
            for (int l = 0; l < LN; l++) begin
                res_reg[l] <= result[l];
            end
            frame_end_reg <= last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = res_reg[0];
    assign m_green_out = res_reg[1];
    assign m_blue_out  = res_reg[2];
    assign m_alpha_out = res_reg[3];
    assign m_frame_end = frame_end_reg;

endmodule

// ----- rtl/core/mbd_checker.sv -----
// Port-level checks for the mipmap downsampler, bound to the top level.
module mbd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [mbd_pkg::PIX_W-1:0]     m_red_out,
    input logic [mbd_pkg::PIX_W-1:0]     m_green_out,
    input logic [mbd_pkg::PIX_W-1:0]     m_blue_out,
    input logic [mbd_pkg::PIX_W-1:0]     m_alpha_out,
    input logic                          m_frame_end
);

    // Input side is free whenever no result is held
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty output register");

    // A new result needs an accepted item in the cycle before
    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an accepted item");

    // After a result is taken, a following one needs a fresh item
    a_no_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> (!m_valid || $past(s_valid && s_ready)))
        else $error("result repeated after it was taken");

    // Stalled result holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_red_out) &&
            $stable(m_green_out) && $stable(m_blue_out) &&
            $stable(m_alpha_out) && $stable(m_frame_end)))
        else $error("stalled result changed");

endmodule

bind mipmap_box_downsample_rgba mbd_checker u_mbd_checker (.*);
